// File: rtl/core/stda_pkg.sv
// Package for the stick-to-dpad translator: payload types, register
// indexes, outcome codes and fixed constants.
// No dependencies.
package stda_pkg;

    // Default parameter values for the top level.
    localparam int STATUS_WIDTH_DEF = 16;
    localparam int UP_MASK_DEF      = 16;
    localparam int RIGHT_MASK_DEF   = 32;
    localparam int DOWN_MASK_DEF    = 64;
    localparam int LEFT_MASK_DEF    = 128;

    // Deadzone radius limits (0.05 and 0.9 in Q0.15) and default click level (0.55).
    localparam logic [15:0] DZ_MIN        = 16'd1638;
    localparam logic [15:0] DZ_MAX        = 16'd29491;
    localparam logic [15:0] CLICK_DEFAULT = 16'd18022;
    localparam logic [15:0] ONE_Q15       = 16'd32768;

    // Reset values of the configuration registers.
    localparam logic [15:0] RADIUS_RESET      = 16'd8192;
    localparam logic [15:0] FIRST_DELAY_RESET = 16'd400;
    localparam logic [15:0] AGAIN_DELAY_RESET = 16'd120;
    localparam logic [29:0] DZ_SQ_RESET       = 30'd67108864;

    // Squared magnitude of a full-scale stick (1.0 * 1.0 in Q2.30).
    localparam logic [31:0] ONE_SQ = 32'h4000_0000;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_CONFIRM_MASK = 3'd0,
        REG_CANCEL_MASK  = 3'd1,
        REG_ALLOWED_MASK = 3'd2,
        REG_DEAD_RADIUS  = 3'd3,
        REG_CLICK_LEVEL  = 3'd4,
        REG_FIRST_DELAY  = 3'd5,
        REG_AGAIN_DELAY  = 3'd6
    } reg_index_t;

    // Result outcome codes.
    typedef enum logic [2:0] {
        OUTCOME_NORMAL  = 3'd0,
        OUTCOME_CLOSED  = 3'd1,
        OUTCOME_BAD_CFG = 3'd2,
        OUTCOME_NO_IN   = 3'd3,
        OUTCOME_YIELDED = 3'd4
    } outcome_t;

    // One controller sample.
    typedef struct packed {
        logic               menu_active;
        logic               sample_valid;
        logic signed [15:0] stick_x;
        logic signed [15:0] stick_y;
        logic        [15:0] trigger_pull;
        logic               face_a;
        logic               face_b;
        logic               pad_known;
        logic        [15:0] pad_status;
        logic        [31:0] time_ms;
    } in_item_t;

    // One frame result.
    typedef struct packed {
        logic [15:0] pulse_status;
        logic        write_now;
        outcome_t    outcome;
        logic        was_clamped;
        logic        did_step;
        logic        did_repeat;
        logic        did_confirm;
        logic        did_cancel;
        logic        was_idle;
    } out_item_t;

endpackage

// File: rtl/core/stda_if.sv
// Valid/ready channel interfaces for the stick-to-dpad translator:
// the sample channel and the result channel.
// No dependencies.
interface stda_in_if;
    logic               valid;
    logic               ready;
    logic               menu_active;
    logic               sample_valid;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic        [15:0] trigger_pull;
    logic               face_a;
    logic               face_b;
    logic               pad_known;
    logic        [15:0] pad_status;
    logic        [31:0] time_ms;

    modport source (
        output valid, menu_active, sample_valid, stick_x, stick_y, trigger_pull,
               face_a, face_b, pad_known, pad_status, time_ms,
        input  ready
    );
    modport sink (
        input  valid, menu_active, sample_valid, stick_x, stick_y, trigger_pull,
               face_a, face_b, pad_known, pad_status, time_ms,
        output ready
    );
endinterface

interface stda_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pulse_status;
    logic        write_now;
    logic [2:0]  outcome;
    logic        was_clamped;
    logic        did_step;
    logic        did_repeat;
    logic        did_confirm;
    logic        did_cancel;
    logic        was_idle;

    modport source (
        output valid, pulse_status, write_now, outcome, was_clamped, did_step,
               did_repeat, did_confirm, did_cancel, was_idle,
        input  ready
    );
    modport sink (
        input  valid, pulse_status, write_now, outcome, was_clamped, did_step,
               did_repeat, did_confirm, did_cancel, was_idle,
        output ready
    );
endinterface

// File: rtl/core/stick_to_dpad_autorepeat.sv
// Top level of the stick-to-dpad translator with auto-repeat.
// Depends on stda_pkg and the channel interfaces in stda_if.sv.
//
// Usage:
// - sample: one controller sample per transfer (stick, trigger, buttons,
//   physical pad status and a wrapping millisecond time).
// - result: one frame result per sample, carrying the pad status bits to
//   pulse, an outcome code and the step, repeat, confirm and cancel flags.
// - cfg_wr_en/cfg_index/cfg_data: register writes, taken at any edge with
//   cfg_wr_en high; write only while no sample is in flight.
// Each sample passes through the sample register and then the result register.
// Throughput is one sample per cycle while the receiver keeps up: the sample
// register feeds combinational logic (two 17-bit squares, an add and compares,
// the 32-bit timer compare) into the result register, and the held direction,
// timer and button levels are updated at that same edge, ready for the next sample.
// The squared deadzone radius is registered from the radius register.
// When the receiver stalls, the result register holds and the sample
// register fills; sample.ready drops only when both are full.
// Reset clears both valid bits, the held direction, the timer and the
// button levels, and loads the register reset values.
module stick_to_dpad_autorepeat
    import stda_pkg::*;
#(
    parameter int STATUS_WIDTH = STATUS_WIDTH_DEF,
    parameter int UP_MASK      = UP_MASK_DEF,
    parameter int RIGHT_MASK   = RIGHT_MASK_DEF,
    parameter int DOWN_MASK    = DOWN_MASK_DEF,
    parameter int LEFT_MASK    = LEFT_MASK_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    stda_in_if.sink     sample,
    stda_out_if.source  result,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Status-width mask and the direction bits, all within 16 bits.
    localparam logic [15:0] STAT_MASK = (STATUS_WIDTH >= 16) ? 16'hFFFF :
                                        16'((32'd1 << STATUS_WIDTH) - 32'd1);
    localparam logic [15:0] UP_BIT    = 16'(UP_MASK);
    localparam logic [15:0] RIGHT_BIT = 16'(RIGHT_MASK);
    localparam logic [15:0] DOWN_BIT  = 16'(DOWN_MASK);
    localparam logic [15:0] LEFT_BIT  = 16'(LEFT_MASK);
    localparam logic [15:0] DIR_ALL   = UP_BIT | RIGHT_BIT | DOWN_BIT | LEFT_BIT;

    // Configuration registers.
    logic [15:0] confirm_mask_reg;
    logic [15:0] cancel_mask_reg;
    logic [15:0] allowed_mask_reg;
    logic [15:0] dead_radius_reg;
    logic [15:0] click_level_reg;
    logic [15:0] first_delay_reg;
    logic [15:0] again_delay_reg;
    logic [29:0] dz_sq_reg;

    // Pipeline registers.
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    // Translator state.
    logic [15:0] held_dir_reg;
    logic [15:0] held_dir_next;
    logic        armed_reg;
    logic        armed_next;
    logic [31:0] fire_time_reg;
    logic [31:0] fire_time_next;
    logic        confirm_prev_reg;
    logic        confirm_prev_next;
    logic        cancel_prev_reg;
    logic        cancel_prev_next;

    logic      advance;
    in_item_t  sample_item;

    // Combinational working values.
    logic [15:0] conf_bits;
    logic [15:0] canc_bits;
    logic        masks_ok;
    logic        yield_pad;
    logic [15:0] click_eff;
    logic        confirm_on;
    logic [16:0] abs_x;
    logic [16:0] abs_y;
    logic [33:0] sq_x;
    logic [33:0] sq_y;
    logic [31:0] mag_sq;
    logic        outside_dz;
    logic [15:0] want_dir;
    logic        timer_due;
    logic [31:0] elapsed;
    logic [15:0] dz_clamped;

    // Handshake: the result register advances when empty or taken.
    assign advance      = !out_valid_reg || result.ready;
    assign sample.ready = !in_valid_reg || advance;

    assign sample_item.menu_active  = sample.menu_active;
    assign sample_item.sample_valid = sample.sample_valid;
    assign sample_item.stick_x      = sample.stick_x;
    assign sample_item.stick_y      = sample.stick_y;
    assign sample_item.trigger_pull = sample.trigger_pull;
    assign sample_item.face_a       = sample.face_a;
    assign sample_item.face_b       = sample.face_b;
    assign sample_item.pad_known    = sample.pad_known;
    assign sample_item.pad_status   = sample.pad_status;
    assign sample_item.time_ms      = sample.time_ms;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirm_mask_reg <= '0;
            cancel_mask_reg  <= '0;
            allowed_mask_reg <= 16'hFFFF;
            dead_radius_reg  <= RADIUS_RESET;
            click_level_reg  <= CLICK_DEFAULT;
            first_delay_reg  <= FIRST_DELAY_RESET;
            again_delay_reg  <= AGAIN_DELAY_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CONFIRM_MASK: confirm_mask_reg <= cfg_data;
                REG_CANCEL_MASK:  cancel_mask_reg  <= cfg_data;
                REG_ALLOWED_MASK: allowed_mask_reg <= cfg_data;
                REG_DEAD_RADIUS:  dead_radius_reg  <= cfg_data;
                REG_CLICK_LEVEL:  click_level_reg  <= cfg_data;
                REG_FIRST_DELAY:  first_delay_reg  <= cfg_data;
                REG_AGAIN_DELAY:  again_delay_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Clamped deadzone radius, squared into a register in the cycle after the radius register.
    always_comb
    begin
        if (dead_radius_reg < DZ_MIN)
            dz_clamped = DZ_MIN;
        else if (dead_radius_reg > DZ_MAX)
            dz_clamped = DZ_MAX;
        else
            dz_clamped = dead_radius_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dz_sq_reg <= DZ_SQ_RESET;
        else
            dz_sq_reg <= 30'(dz_clamped[14:0] * dz_clamped[14:0]);
    end

    // Mask checks, button levels and the physical-pad yield test.
    always_comb
    begin
        conf_bits = confirm_mask_reg & STAT_MASK;
        canc_bits = cancel_mask_reg & STAT_MASK;
        masks_ok  = (conf_bits != '0) && (canc_bits != '0)
                    && ((conf_bits & canc_bits) == '0)
                    && (((conf_bits | canc_bits) & DIR_ALL) == '0)
                    && (((conf_bits | canc_bits) & ~allowed_mask_reg) == '0);
        yield_pad = in_item_reg.pad_known
                    && ((in_item_reg.pad_status & (DIR_ALL | conf_bits | canc_bits)) != '0);

        if (click_level_reg == '0 || click_level_reg > ONE_Q15)
            click_eff = CLICK_DEFAULT;
        else
            click_eff = click_level_reg;
        confirm_on = in_item_reg.face_a || (in_item_reg.trigger_pull >= click_eff);
    end

    // Stick magnitude, deadzone test and direction choice.
    always_comb
    begin
        abs_x = in_item_reg.stick_x[15] ? (17'd0 - {in_item_reg.stick_x[15], in_item_reg.stick_x})
                                        : {1'b0, in_item_reg.stick_x};
        abs_y = in_item_reg.stick_y[15] ? (17'd0 - {in_item_reg.stick_y[15], in_item_reg.stick_y})
                                        : {1'b0, in_item_reg.stick_y};
        sq_x       = abs_x * abs_x;
        sq_y       = abs_y * abs_y;
        mag_sq     = 32'(sq_x) + 32'(sq_y);
        outside_dz = mag_sq > {2'b00, dz_sq_reg};

        want_dir = '0;
        if (outside_dz)
        begin
            if (abs_y >= abs_x)
                want_dir = (!in_item_reg.stick_y[15] && in_item_reg.stick_y != '0) ? UP_BIT
                                                                                   : DOWN_BIT;
            else
                want_dir = (!in_item_reg.stick_x[15] && in_item_reg.stick_x != '0) ? RIGHT_BIT
                                                                                   : LEFT_BIT;
            want_dir = want_dir & STAT_MASK;
        end

        // Wrap-safe deadline test on the signed difference.
        elapsed   = in_item_reg.time_ms - fire_time_reg;
        timer_due = !elapsed[31];
    end

    // Outcome selection, state update and result fields.
    always_comb
    begin
        held_dir_next     = held_dir_reg;
        armed_next        = armed_reg;
        fire_time_next    = fire_time_reg;
        confirm_prev_next = confirm_prev_reg;
        cancel_prev_next  = cancel_prev_reg;
        out_item_next     = '0;

        if (!in_item_reg.menu_active)
        begin
            held_dir_next     = '0;
            armed_next        = 1'b0;
            fire_time_next    = '0;
            confirm_prev_next = confirm_on;
            cancel_prev_next  = in_item_reg.face_b;
            out_item_next.outcome = OUTCOME_CLOSED;
        end
        else if (!masks_ok)
        begin
            held_dir_next  = '0;
            armed_next     = 1'b0;
            fire_time_next = '0;
            out_item_next.outcome = OUTCOME_BAD_CFG;
        end
        else if (!in_item_reg.sample_valid)
        begin
            held_dir_next = '0;
            armed_next    = 1'b0;
            out_item_next.outcome = OUTCOME_NO_IN;
        end
        else if (yield_pad)
        begin
            held_dir_next     = '0;
            armed_next        = 1'b0;
            confirm_prev_next = confirm_on;
            cancel_prev_next  = in_item_reg.face_b;
            out_item_next.outcome = OUTCOME_YIELDED;
        end
        else
        begin
            out_item_next.outcome     = OUTCOME_NORMAL;
            out_item_next.was_clamped = mag_sq > ONE_SQ;

            // A new direction steps at once; a held one repeats when due.
            if (want_dir != held_dir_reg)
            begin
                held_dir_next = want_dir;
                if (want_dir != '0)
                begin
                    out_item_next.pulse_status = want_dir;
                    out_item_next.did_step     = 1'b1;
                    fire_time_next = in_item_reg.time_ms + {16'd0, first_delay_reg};
                    armed_next     = 1'b1;
                end
                else
                begin
                    armed_next = 1'b0;
                end
            end
            else if (want_dir != '0 && armed_reg && timer_due)
            begin
                out_item_next.pulse_status = want_dir;
                out_item_next.did_step     = 1'b1;
                out_item_next.did_repeat   = 1'b1;
                fire_time_next = in_item_reg.time_ms + {16'd0, again_delay_reg};
            end

            // Confirm and cancel pulse on rising edges.
            if (confirm_on && !confirm_prev_reg)
            begin
                out_item_next.pulse_status = out_item_next.pulse_status | conf_bits;
                out_item_next.did_confirm  = 1'b1;
            end
            if (in_item_reg.face_b && !cancel_prev_reg)
            begin
                out_item_next.pulse_status = out_item_next.pulse_status | canc_bits;
                out_item_next.did_cancel   = 1'b1;
            end
            confirm_prev_next = confirm_on;
            cancel_prev_next  = in_item_reg.face_b;

            out_item_next.write_now = out_item_next.pulse_status != '0;
            out_item_next.was_idle  = out_item_next.pulse_status == '0;
        end
    end

    // Sample register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (sample.valid && sample.ready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
            in_item_reg <= sample_item;
    end

    // Result register and state, updated together when a sample is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            held_dir_reg     <= '0;
            armed_reg        <= 1'b0;
            fire_time_reg    <= '0;
            confirm_prev_reg <= 1'b0;
            cancel_prev_reg  <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                held_dir_reg     <= held_dir_next;
                armed_reg        <= armed_next;
                fire_time_reg    <= fire_time_next;
                confirm_prev_reg <= confirm_prev_next;
                cancel_prev_reg  <= cancel_prev_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            out_item_reg <= out_item_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.pulse_status = out_item_reg.pulse_status;
    assign result.write_now    = out_item_reg.write_now;
    assign result.outcome      = out_item_reg.outcome;
    assign result.was_clamped  = out_item_reg.was_clamped;
    assign result.did_step     = out_item_reg.did_step;
    assign result.did_repeat   = out_item_reg.did_repeat;
    assign result.did_confirm  = out_item_reg.did_confirm;
    assign result.did_cancel   = out_item_reg.did_cancel;
    assign result.was_idle     = out_item_reg.was_idle;

`ifndef SYNTH
    // An armed timer always belongs to a held direction.
    a_armed_has_dir: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |-> (held_dir_reg != '0))
        else $error("repeat timer armed with no held direction");

    // A result other than normal carries no pulse and no flags.
    a_abnormal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.outcome != OUTCOME_NORMAL) |->
        (out_item_reg.pulse_status == '0 && !out_item_reg.write_now
         && !out_item_reg.did_step && !out_item_reg.did_confirm
         && !out_item_reg.did_cancel && !out_item_reg.was_idle
         && !out_item_reg.was_clamped))
        else $error("non-normal outcome with active result fields");

    // A repeat is always a step.
    a_repeat_is_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.did_repeat) |-> out_item_reg.did_step)
        else $error("repeat flagged without a step");

    // A sample that cannot move on stays in the sample register.
    a_sample_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("stalled sample lost");

    // A processed sample always produces a valid result.
    a_sample_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> out_valid_reg)
        else $error("processed sample produced no result");
`endif

endmodule

// File: verif/testbench.sv
// Self-checking testbench for stick_to_dpad_autorepeat: directed frames, then phases of
// random controller samples under changing register settings, with random idling on both sides.
// Depends on stda_pkg, the channel interfaces in stda_if.sv and the top level.
module testbench;
    import stda_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 200000;
    localparam logic [15:0] DIR_BITS =
        16'(UP_MASK_DEF | RIGHT_MASK_DEF | DOWN_MASK_DEF | LEFT_MASK_DEF);

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    stda_in_if  s_if ();
    stda_out_if r_if ();

    stick_to_dpad_autorepeat i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (s_if),
        .result    (r_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Queues between stimulus, driver and monitor.
    in_item_t  pending_samples[$];
    out_item_t expected_frames[$];
    in_item_t  drv_item;
    int        n_queued  = 0;
    int        n_checked = 0;
    int        errors    = 0;
    int        cycles    = 0;
    int        drv_gap;
    int        mon_stall;
    bit        drv_quiet = 1'b0;
    bit        mon_quiet = 1'b0;

    // Register copies held by the predictor.
    logic [15:0] m_confirm, m_cancel, m_allowed, m_radius, m_click, m_first, m_again;

    // Predicted translator state.
    logic [15:0] held_dir;
    bit          armed;
    logic [31:0] fire_at;
    bit          confirm_last, cancel_last;

    // Random sample generator state.
    logic [31:0] gen_time = 32'd0;
    int          gen_step = 20;
    int          gen_hold = 0;
    int          gen_x = 0, gen_y = 0, gen_trig = 0;
    bit          gen_a = 1'b0, gen_b = 1'b0;

    // Random wait for one item, with stretches of no waiting at all.
    function automatic int draw_wait(inout bit quiet);
        if ($urandom_range(0, 39) == 0)
        begin
            quiet = !quiet;
        end
        return quiet ? 0 : int'($urandom_range(0, 13));
    endfunction

    // Confirm is face A or the trigger at or above the effective click level.
    function automatic bit confirm_held(in_item_t s);
        logic [15:0] lvl;
        lvl = (m_click == 16'd0 || m_click > ONE_Q15) ? CLICK_DEFAULT : m_click;
        return s.face_a || (s.trigger_pull >= lvl);
    endfunction

    // Expected frame for one accepted sample; advances the predicted state.
    function automatic out_item_t predict_frame(in_item_t s);
        out_item_t   r;
        logic [15:0] both, dz, want;
        logic [16:0] ax, ay;
        logic [34:0] mag;
        logic [31:0] late;
        bit          press, back;
        r = '0;
        both = m_confirm | m_cancel;
        if (!s.menu_active)
        begin
            held_dir = 16'd0;
            armed = 1'b0;
            fire_at = 32'd0;
            confirm_last = confirm_held(s);
            cancel_last = s.face_b;
            r.outcome = OUTCOME_CLOSED;
            return r;
        end
        if (m_confirm == 16'd0 || m_cancel == 16'd0 || (m_confirm & m_cancel) != 16'd0 ||
            (both & (DIR_BITS | ~m_allowed)) != 16'd0)
        begin
            held_dir = 16'd0;
            armed = 1'b0;
            fire_at = 32'd0;
            r.outcome = OUTCOME_BAD_CFG;
            return r;
        end
        if (!s.sample_valid)
        begin
            held_dir = 16'd0;
            armed = 1'b0;
            r.outcome = OUTCOME_NO_IN;
            return r;
        end
        if (s.pad_known && (s.pad_status & (DIR_BITS | both)) != 16'd0)
        begin
            held_dir = 16'd0;
            armed = 1'b0;
            confirm_last = confirm_held(s);
            cancel_last = s.face_b;
            r.outcome = OUTCOME_YIELDED;
            return r;
        end

        // Deadzone test on the squared magnitude, clamped to full scale.
        dz = m_radius;
        if (dz < DZ_MIN) dz = DZ_MIN;
        if (dz > DZ_MAX) dz = DZ_MAX;
        ax = s.stick_x[15] ? 17'd0 - {1'b1, s.stick_x} : {1'b0, s.stick_x};
        ay = s.stick_y[15] ? 17'd0 - {1'b1, s.stick_y} : {1'b0, s.stick_y};
        mag = 35'(ax) * 35'(ax) + 35'(ay) * 35'(ay);
        if (mag > 35'(ONE_SQ))
        begin
            r.was_clamped = 1'b1;
            mag = 35'(ONE_SQ);
        end
        want = 16'd0;
        if (mag > 35'(dz) * 35'(dz))
        begin
            if (ay >= ax)
                want = ($signed(s.stick_y) > 16'sd0) ? 16'(UP_MASK_DEF) : 16'(DOWN_MASK_DEF);
            else
                want = ($signed(s.stick_x) > 16'sd0) ? 16'(RIGHT_MASK_DEF) : 16'(LEFT_MASK_DEF);
        end

        // Step on a change of direction, repeat when the wrap-safe deadline is due.
        late = s.time_ms - fire_at;
        if (want != held_dir)
        begin
            held_dir = want;
            if (want != 16'd0)
            begin
                r.pulse_status |= want;
                r.did_step = 1'b1;
                fire_at = s.time_ms + 32'(m_first);
                armed = 1'b1;
            end
            else
            begin
                armed = 1'b0;
            end
        end
        else if (want != 16'd0 && armed && !late[31])
        begin
            r.pulse_status |= want;
            r.did_step = 1'b1;
            r.did_repeat = 1'b1;
            fire_at = s.time_ms + 32'(m_again);
        end

        // Confirm and cancel pulse on rising edges only.
        press = confirm_held(s);
        back = s.face_b;
        if (press && !confirm_last)
        begin
            r.pulse_status |= m_confirm;
            r.did_confirm = 1'b1;
        end
        if (back && !cancel_last)
        begin
            r.pulse_status |= m_cancel;
            r.did_cancel = 1'b1;
        end
        confirm_last = press;
        cancel_last = back;
        r.write_now = (r.pulse_status != 16'd0);
        r.was_idle = (r.pulse_status == 16'd0);
        r.outcome = OUTCOME_NORMAL;
        return r;
    endfunction

    function automatic void diff_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic int extreme_pick();
        case ($urandom_range(0, 2))
            0:       return -32768;
            1:       return 32767;
            default: return 0;
        endcase
    endfunction

    function automatic in_item_t mk(bit menu, bit valid, int x, int y, int trig, bit a, bit b,
                                    bit known, int pad, logic [31:0] t);
        in_item_t s;
        s.menu_active  = menu;
        s.sample_valid = valid;
        s.stick_x      = 16'(x);
        s.stick_y      = 16'(y);
        s.trigger_pull = 16'(trig);
        s.face_a       = a;
        s.face_b       = b;
        s.pad_known    = known;
        s.pad_status   = 16'(pad);
        s.time_ms      = t;
        return s;
    endfunction

    // Next random sample: stick positions held over runs of samples, and button levels that toggle at random.
    function automatic in_item_t next_sample();
        in_item_t s;
        int       mag, off, dz;
        if ($urandom_range(0, 32) == 0)
            gen_time = $urandom;
        else
            gen_time += $urandom_range(0, gen_step);
        if (gen_hold == 0)
        begin
            gen_hold = $urandom_range(1, 24);
            case ($urandom_range(0, 5))
                0:
                begin
                    gen_x = int'($urandom_range(0, 3000)) - 1500;
                    gen_y = int'($urandom_range(0, 3000)) - 1500;
                end
                1, 2:
                begin
                    mag = $urandom_range(2000, 32767);
                    off = $urandom_range(0, mag / 2);
                    if ($urandom_range(0, 1)) mag = -mag;
                    if ($urandom_range(0, 1)) off = -off;
                    if ($urandom_range(0, 1))
                    begin
                        gen_x = mag;
                        gen_y = off;
                    end
                    else
                    begin
                        gen_x = off;
                        gen_y = mag;
                    end
                end
                3:
                begin
                    gen_x = int'($urandom_range(0, 65535)) - 32768;
                    gen_y = int'($urandom_range(0, 65535)) - 32768;
                end
                4:
                begin
                    gen_x = extreme_pick();
                    gen_y = extreme_pick();
                end
                default:
                begin
                    // Right at the edge of the clamped deadzone on one axis.
                    dz = int'(m_radius);
                    if (dz < int'(DZ_MIN)) dz = int'(DZ_MIN);
                    if (dz > int'(DZ_MAX)) dz = int'(DZ_MAX);
                    mag = dz + int'($urandom_range(0, 4)) - 2;
                    if ($urandom_range(0, 1)) mag = -mag;
                    if ($urandom_range(0, 1))
                    begin
                        gen_x = mag;
                        gen_y = 0;
                    end
                    else
                    begin
                        gen_x = 0;
                        gen_y = mag;
                    end
                end
            endcase
        end
        else
        begin
            gen_hold--;
        end
        if ($urandom_range(0, 5) == 0) gen_a = !gen_a;
        if ($urandom_range(0, 5) == 0) gen_b = !gen_b;
        if ($urandom_range(0, 7) == 0) gen_trig = $urandom_range(0, 32768);

        s.menu_active  = ($urandom_range(0, 29) != 0);
        s.sample_valid = ($urandom_range(0, 24) != 0);
        s.stick_x      = 16'(gen_x);
        s.stick_y      = 16'(gen_y);
        s.trigger_pull = 16'(gen_trig);
        s.face_a       = gen_a;
        s.face_b       = gen_b;
        s.pad_known    = 1'($urandom_range(0, 1));
        s.pad_status   = 16'($urandom);
        if ($urandom_range(0, 9) != 0)
        begin
            s.pad_status &= ~(DIR_BITS | m_confirm | m_cancel);
        end
        s.time_ms = gen_time;
        return s;
    endfunction

    task automatic queue_sample(in_item_t s);
        pending_samples.push_back(s);
        n_queued++;
    endtask

    // Wait until every queued sample has its result checked, then a short pause.
    task automatic settle();
        while (n_checked != n_queued) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_CONFIRM_MASK: m_confirm = val;
            REG_CANCEL_MASK:  m_cancel  = val;
            REG_ALLOWED_MASK: m_allowed = val;
            REG_DEAD_RADIUS:  m_radius  = val;
            REG_CLICK_LEVEL:  m_click   = val;
            REG_FIRST_DELAY:  m_first   = val;
            REG_AGAIN_DELAY:  m_again   = val;
            default: ;
        endcase
    endtask

    // Load all seven registers while the block is idle.
    task automatic set_regs(logic [15:0] c, logic [15:0] k, logic [15:0] a, logic [15:0] rad,
                            logic [15:0] clk_lvl, logic [15:0] first, logic [15:0] again);
        settle();
        write_reg(REG_CONFIRM_MASK, c);
        write_reg(REG_CANCEL_MASK, k);
        write_reg(REG_ALLOWED_MASK, a);
        write_reg(REG_DEAD_RADIUS, rad);
        write_reg(REG_CLICK_LEVEL, clk_lvl);
        write_reg(REG_FIRST_DELAY, first);
        write_reg(REG_AGAIN_DELAY, again);
        // The squared radius is registered in the cycle after the radius register.
        repeat (3) @(posedge clk);
    endtask

    // Sample driver: presents queued samples and predicts each transfer.
    always @(posedge clk)
    begin : drive_samples
        in_item_t nxt;
        if (!rst_n)
        begin
            s_if.valid <= 1'b0;
            drv_gap <= 0;
        end
        else
        begin
            if (s_if.valid && s_if.ready)
            begin
                expected_frames.push_back(predict_frame(drv_item));
            end
            if (!s_if.valid || s_if.ready)
            begin
                if (drv_gap > 0)
                begin
                    s_if.valid <= 1'b0;
                    drv_gap <= drv_gap - 1;
                end
                else if (pending_samples.size() > 0)
                begin
                    nxt = pending_samples.pop_front();
                    drv_item <= nxt;
                    s_if.menu_active  <= nxt.menu_active;
                    s_if.sample_valid <= nxt.sample_valid;
                    s_if.stick_x      <= nxt.stick_x;
                    s_if.stick_y      <= nxt.stick_y;
                    s_if.trigger_pull <= nxt.trigger_pull;
                    s_if.face_a       <= nxt.face_a;
                    s_if.face_b       <= nxt.face_b;
                    s_if.pad_known    <= nxt.pad_known;
                    s_if.pad_status   <= nxt.pad_status;
                    s_if.time_ms      <= nxt.time_ms;
                    s_if.valid        <= 1'b1;
                    drv_gap <= draw_wait(drv_quiet);
                end
                else
                begin
                    s_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transfer against the oldest expected frame.
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        int        n;
        if (!rst_n)
        begin
            r_if.ready <= 1'b0;
            mon_stall <= 0;
        end
        else if (r_if.valid && r_if.ready)
        begin
            if (expected_frames.size() == 0)
            begin
                $display("%0t: result transfer with no expected frame, outcome %0h", $time,
                         r_if.outcome);
                errors++;
            end
            else
            begin
                want = expected_frames.pop_front();
                diff_field("pulse_status", want.pulse_status, r_if.pulse_status);
                diff_field("write_now", want.write_now, r_if.write_now);
                diff_field("outcome", want.outcome, r_if.outcome);
                diff_field("was_clamped", want.was_clamped, r_if.was_clamped);
                diff_field("did_step", want.did_step, r_if.did_step);
                diff_field("did_repeat", want.did_repeat, r_if.did_repeat);
                diff_field("did_confirm", want.did_confirm, r_if.did_confirm);
                diff_field("did_cancel", want.did_cancel, r_if.did_cancel);
                diff_field("was_idle", want.was_idle, r_if.was_idle);
            end
            n_checked++;
            n = draw_wait(mon_quiet);
            if (n == 0)
            begin
                r_if.ready <= 1'b1;
            end
            else
            begin
                r_if.ready <= 1'b0;
                mon_stall <= n;
            end
        end
        else if (!r_if.ready)
        begin
            if (mon_stall <= 1) r_if.ready <= 1'b1;
            if (mon_stall > 0) mon_stall <= mon_stall - 1;
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus: reset, directed frames, then random phases.
    initial
    begin
        int          cb, kb, count;
        logic [15:0] cm, km, am;

        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = 3'd0;
        cfg_data = 16'd0;
        s_if.valid = 1'b0;
        s_if.menu_active = 1'b0;
        s_if.sample_valid = 1'b0;
        s_if.stick_x = 16'd0;
        s_if.stick_y = 16'd0;
        s_if.trigger_pull = 16'd0;
        s_if.face_a = 1'b0;
        s_if.face_b = 1'b0;
        s_if.pad_known = 1'b0;
        s_if.pad_status = 16'd0;
        s_if.time_ms = 32'd0;
        drv_item = '0;

        m_confirm = 16'd0;
        m_cancel = 16'd0;
        m_allowed = 16'hFFFF;
        m_radius = RADIUS_RESET;
        m_click = CLICK_DEFAULT;
        m_first = FIRST_DELAY_RESET;
        m_again = AGAIN_DELAY_RESET;
        held_dir = 16'd0;
        armed = 1'b0;
        fire_at = 32'd0;
        confirm_last = 1'b0;
        cancel_last = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset masks are zero: closed window, then a bad mask pair.
        queue_sample(mk(0, 1, 0, 0, 0, 0, 0, 0, 0, 32'd5));
        queue_sample(mk(1, 1, 20000, 0, 0, 1, 0, 0, 0, 32'd6));

        // Smallest radius and smallest nonzero delays; click level zero falls back to the default.
        set_regs(16'h0001, 16'h0002, 16'hFFFF, 16'd0, 16'd0, 16'd1, 16'd1);
        queue_sample(mk(0, 1, 0, 0, 0, 1, 0, 0, 0, 32'd99));
        queue_sample(mk(1, 1, 0, 0, 0, 1, 0, 0, 0, 32'd100));
        queue_sample(mk(1, 1, 0, 0, 18021, 0, 1, 0, 0, 32'd101));
        queue_sample(mk(1, 1, 0, 0, 18022, 0, 0, 0, 0, 32'd102));
        queue_sample(mk(1, 1, 1638, 0, 0, 0, 0, 0, 0, 32'd103));
        queue_sample(mk(1, 1, 1639, 0, 0, 0, 0, 0, 0, 32'd104));
        queue_sample(mk(1, 1, 1639, 0, 0, 0, 0, 0, 0, 32'd105));
        queue_sample(mk(1, 1, -32768, -32768, 0, 0, 0, 0, 0, 32'd106));
        queue_sample(mk(1, 1, -32768, 0, 0, 0, 0, 0, 0, 32'd107));
        queue_sample(mk(1, 1, 0, 32767, 0, 0, 0, 0, 0, 32'd108));
        queue_sample(mk(1, 1, 32767, -32768, 32768, 0, 0, 0, 0, 32'd109));
        queue_sample(mk(1, 0, 32767, 0, 0, 0, 0, 0, 0, 32'd110));
        queue_sample(mk(1, 1, 0, 32767, 0, 0, 0, 1, 16'h0010, 32'd111));
        // Pad bits outside direction, confirm and cancel do not yield; tick wraps.
        queue_sample(mk(1, 1, 0, 32767, 0, 0, 0, 1, 16'hFF0C, 32'hFFFF_FFFF));
        queue_sample(mk(1, 1, 0, 32767, 0, 0, 0, 0, 0, 32'd0));
        queue_sample(mk(1, 1, 0, 32767, 0, 0, 0, 0, 0, 32'd0));
        queue_sample(mk(1, 1, 0, 0, 0, 1, 1, 0, 16'hFFFF, 32'd1));

        // Bad mask pairs: overlap, a direction bit, outside allowed, nothing allowed.
        set_regs(16'h0003, 16'h0002, 16'hFFFF, 16'd8192, 16'd18022, 16'd400, 16'd120);
        queue_sample(mk(1, 1, 20000, 0, 0, 1, 0, 0, 0, 32'd10));
        set_regs(16'h0010, 16'h0001, 16'hFFFF, 16'd8192, 16'd18022, 16'd400, 16'd120);
        queue_sample(mk(1, 1, 20000, 0, 0, 1, 0, 0, 0, 32'd11));
        set_regs(16'h0001, 16'h0002, 16'h0001, 16'd8192, 16'd18022, 16'd400, 16'd120);
        queue_sample(mk(1, 1, 20000, 0, 0, 1, 0, 0, 0, 32'd12));
        set_regs(16'h0001, 16'h0002, 16'h0000, 16'd8192, 16'd18022, 16'd400, 16'd120);
        queue_sample(mk(1, 1, 20000, 0, 0, 1, 0, 0, 0, 32'd13));

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 9; ph++)
        begin
            count = 85;
            gen_step = 40;
            case (ph)
                0:
                begin
                    set_regs(16'h0001, 16'h0002, 16'hFFFF, 16'd8192, 16'd18022, 16'd40,
                             16'd15);
                    gen_step = 20;
                end
                1:
                begin
                    // Delays of zero make every held frame due.
                    set_regs(16'h8000, 16'h0100, 16'h8100, 16'd32768, 16'd32768, 16'd0,
                             16'd0);
                    gen_step = 20;
                end
                2:
                begin
                    set_regs(16'h0E00, 16'h300F, 16'h3E0F, 16'd1638, 16'd1, 16'd65535,
                             16'd65535);
                    gen_step = 6000;
                end
                3:
                begin
                    set_regs(16'h0004, 16'h4000, 16'hFFFF, 16'd29491, 16'd0, 16'd1, 16'd1);
                    gen_time = 32'hFFFF_FF00;
                    gen_step = 3;
                end
                4:
                begin
                    // Arbitrary masks, mostly rejected as a bad pair.
                    set_regs(16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                             16'($urandom_range(1, 300)), 16'($urandom_range(1, 100)));
                    count = 40;
                end
                default:
                begin
                    cb = $urandom_range(0, 11);
                    kb = (cb + int'($urandom_range(1, 11))) % 12;
                    cm = 16'd1 << (cb < 4 ? cb : cb + 4);
                    km = 16'd1 << (kb < 4 ? kb : kb + 4);
                    am = $urandom_range(0, 1) ? 16'hFFFF : (cm | km);
                    set_regs(cm, km, am, 16'($urandom_range(0, 32768)),
                             16'($urandom_range(0, 32768)), 16'($urandom_range(1, 500)),
                             16'($urandom_range(1, 200)));
                end
            endcase
            repeat (count) queue_sample(next_sample());
        end

        // Drain, then a few cycles to catch any stray result.
        while (n_checked != n_queued) @(posedge clk);
        repeat (10) @(posedge clk);
        if (expected_frames.size() != 0)
        begin
            $display("%0t: %0d expected frames never arrived", $time, expected_frames.size());
            errors++;
        end
        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/stda_pkg.sv
rtl/core/stda_if.sv
rtl/core/stick_to_dpad_autorepeat.sv
verif/testbench.sv
